// ----- sv/gcmr_pkg.sv -----
package gcmr_pkg;

  // Field and datapath widths.
  localparam int unsigned HalfW   = 64;
  localparam int unsigned OpW     = 2 * HalfW;
  localparam int unsigned AccW    = 2 * OpW;
  localparam int unsigned DigitW  = 16;
  localparam int unsigned NumStep = OpW / DigitW;
  localparam int unsigned ProdW   = OpW + DigitW;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLow  = 2'd0,
    CfgKeyHigh = 2'd1
  } cfg_idx_e;

  // Input item: operand A, low half in the low bits.
  typedef struct packed {
    logic [HalfW-1:0] operand_high;
    logic [HalfW-1:0] operand_low;
  } operand_t;

  // Result item: reduced product, low half in the low bits.
  typedef struct packed {
    logic [HalfW-1:0] product_high;
    logic [HalfW-1:0] product_low;
  } result_t;

  // Contents of one multiply stage register.
  typedef struct packed {
    logic            valid;
    logic [AccW-1:0] acc;
    logic [OpW-1:0]  opnd;
  } stage_t;

  // Carry-less product of one operand digit and the full key.
  function automatic logic [ProdW-1:0] clmul_digit(input logic [DigitW-1:0] d,
                                                   input logic [OpW-1:0]    h);
    logic [ProdW-1:0] r;
    r = '0;
    for (int i = 0; i < DigitW; i++) begin
      if (d[i]) begin
        r = r ^ ({{DigitW{1'b0}}, h} << i);
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/gf128_carryless_multiply_reduce.sv -----
// Fixed-key multiplier in GF(2^128), plain polynomial basis, modulus
// x^128 + x^7 + x^2 + x + 1.
//
// Configuration: the key H is written through the cfg channel, index 0 for
// bits 63..0 and index 1 for bits 127..64; cfg_ready_o is always high and a
// transfer happens when cfg_valid_i is high. Other indexes are ignored. The
// key may only change while no item is in flight.
//
// Operands: an item is accepted at each clock edge where start_i is high and
// busy_o is low. busy_o never rises, so one item is taken every cycle.
// Results: result_valid_o strobes for one cycle with result_o; the receiver
// has no way to stall, so the pipeline never holds.
//
// Eight multiply stages each fold in one 16-bit digit of the operand (Horner
// order, top digit first), and one stage reduces the 256-bit product.
// Throughput is one item per cycle.
// Reset clears the key to zero and empties the pipeline.
module gf128_carryless_multiply_reduce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  gcmr_pkg::operand_t                operand_i,
  output logic                              result_valid_o,
  output gcmr_pkg::result_t                 result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gcmr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [gcmr_pkg::HalfW-1:0]        cfg_data_i
);
  import gcmr_pkg::*;

  logic [HalfW-1:0] key_lo_q, key_hi_q;
  logic [OpW-1:0]   key;
  stage_t           stage [NumStep+1];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign key         = {key_hi_q, key_lo_q};

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKeyLow:  key_lo_q <= cfg_data_i;
        CfgKeyHigh: key_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline entry: empty partial product, operand as the digit source.
  assign stage[0] = '{valid: start_i && !busy_o, acc: '0,
                      opnd: {operand_i.operand_high, operand_i.operand_low}};

  // Multiply stages, one operand digit each.
  for (genvar k = 0; k < NumStep; k++) begin : g_step
    gcmr_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage[k]),
      .key_i   (key),
      .stage_o (stage[k+1])
    );
  end

  // Final reduction and output register.
  gcmr_reduce u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage[NumStep]),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  // An item leaving the first stage was accepted in the cycle before.
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage[1].valid |-> $past(start_i && !busy_o))
    else $error("first stage valid without an accepted item");

  // The middle of the pipeline moves every item by one stage per cycle.
  a_middle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage[NumStep/2+1].valid == $past(stage[NumStep/2].valid))
    else $error("pipeline valid bit lost or invented");

  // A result strobe comes in the cycle after the last multiply stage holds a valid item.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == $past(stage[NumStep].valid))
    else $error("result strobe out of step with the pipeline");
`endif

endmodule

// ----- sv/gcmr_step.sv -----
module gcmr_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gcmr_pkg::stage_t           stage_i,
  input  logic [gcmr_pkg::OpW-1:0]   key_i,
  output gcmr_pkg::stage_t           stage_o
);
  import gcmr_pkg::*;

  logic             vld_q;
  logic [AccW-1:0]  acc_d, acc_q;
  logic [OpW-1:0]   opnd_d, opnd_q;
  logic [ProdW-1:0] part;

  // Horner step: shift the partial product up one digit and add the
  // product of the key with the top remaining digit of the operand.
  assign part   = clmul_digit(stage_i.opnd[OpW-1 -: DigitW], key_i);
  assign acc_d  = {stage_i.acc[AccW-DigitW-1:0], {DigitW{1'b0}}}
                ^ {{(AccW-ProdW){1'b0}}, part};
  assign opnd_d = {stage_i.opnd[OpW-DigitW-1:0], {DigitW{1'b0}}};

  // Valid bit is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.valid;
    end
  end

  // Payload registers load only with a valid item.
  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      acc_q  <= acc_d;
      opnd_q <= opnd_d;
    end
  end

  assign stage_o = '{valid: vld_q, acc: acc_q, opnd: opnd_q};

endmodule

// ----- sv/gcmr_reduce.sv -----
module gcmr_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcmr_pkg::stage_t  stage_i,
  output logic              valid_o,
  output gcmr_pkg::result_t result_o
);
  import gcmr_pkg::*;

  localparam int unsigned OvW = 7;

  logic              vld_q;
  logic [OpW-1:0]    hi;
  logic [OpW+OvW-1:0] fold1;
  logic [OvW-1:0]    ovf;
  logic [2*OvW-1:0]  fold2;
  logic [OpW-1:0]    res_d, res_q;

  // First fold: x^128 is x^7 + x^2 + x + 1, so the upper half times that
  // polynomial lands below x^135.
  assign hi    = stage_i.acc[AccW-1:OpW];
  assign fold1 = {{OvW{1'b0}}, hi}
               ^ {{(OvW-1){1'b0}}, hi, 1'b0}
               ^ {{(OvW-2){1'b0}}, hi, 2'b0}
               ^ {hi, {OvW{1'b0}}};

  // Second fold of the seven overflow bits stays well below x^128.
  assign ovf   = fold1[OpW+OvW-1:OpW];
  assign fold2 = {{OvW{1'b0}}, ovf}
               ^ {{(OvW-1){1'b0}}, ovf, 1'b0}
               ^ {{(OvW-2){1'b0}}, ovf, 2'b0}
               ^ {ovf, {OvW{1'b0}}};

  assign res_d = stage_i.acc[OpW-1:0] ^ fold1[OpW-1:0]
               ^ {{(OpW-2*OvW){1'b0}}, fold2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = vld_q;
  assign result_o = '{product_high: res_q[OpW-1:HalfW], product_low: res_q[HalfW-1:0]};

endmodule
